[rtl/se3pc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// se3pc_pkg: shared types and constants of the SE(3) pose composition block
// Field widths, the configuration register map and the frame transform
// bundle that the register file hands to both datapaths.
// ----------------------------------------------------------------------------
package se3pc_pkg;

  localparam int unsigned POS_W      = 32;  // signed position fields
  localparam int unsigned QUAT_W     = 16;  // signed quaternion components
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned NUM_STAGES = 5;   // register stages from input to output

  // Reset value of the frame scalar part: 1.0 in the default quaternion format.
  localparam logic [QUAT_W-1:0] FRAME_QW_RESET = 16'd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_TX = 3'd0,
    REG_FRAME_TY = 3'd1,
    REG_FRAME_TZ = 3'd2,
    REG_FRAME_QX = 3'd3,
    REG_FRAME_QY = 3'd4,
    REG_FRAME_QZ = 3'd5,
    REG_FRAME_QW = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [POS_W-1:0]  tx;
    logic [POS_W-1:0]  ty;
    logic [POS_W-1:0]  tz;
    logic [QUAT_W-1:0] qx;
    logic [QUAT_W-1:0] qy;
    logic [QUAT_W-1:0] qz;
    logic [QUAT_W-1:0] qw;
  } frame_cfg_t;

endpackage
`default_nettype wire

[rtl/se3pc_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// se3pc_cfg_regs: frame transform register file
// Holds the fixed translation and rotation quaternion. Writes to an index
// outside the register map are dropped.
// ----------------------------------------------------------------------------
module se3pc_cfg_regs
  import se3pc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output frame_cfg_t            cfg_o
);

  frame_cfg_t cfg_q, cfg_d;

  // The register file can take a write in every cycle.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_FRAME_TX: cfg_d.tx = cfg_data_i[POS_W-1:0];
        REG_FRAME_TY: cfg_d.ty = cfg_data_i[POS_W-1:0];
        REG_FRAME_TZ: cfg_d.tz = cfg_data_i[POS_W-1:0];
        REG_FRAME_QX: cfg_d.qx = cfg_data_i[QUAT_W-1:0];
        REG_FRAME_QY: cfg_d.qy = cfg_data_i[QUAT_W-1:0];
        REG_FRAME_QZ: cfg_d.qz = cfg_data_i[QUAT_W-1:0];
        REG_FRAME_QW: cfg_d.qw = cfg_data_i[QUAT_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{tx: '0, ty: '0, tz: '0, qx: '0, qy: '0, qz: '0, qw: FRAME_QW_RESET};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

[rtl/se3pc_pos_path.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// se3pc_pos_path: position rotation and translation pipeline
// Five stages: p*conj(q) products, sums, q*u products, sums, then the
// translation add with saturation.
// ----------------------------------------------------------------------------
module se3pc_pos_path
  import se3pc_pkg::*;
#(
  parameter int unsigned QUAT_FRAC_BITS = 14
) (
  input  logic                    clk_i,
  input  logic                    adv_i,
  input  frame_cfg_t              cfg_i,
  input  logic signed [POS_W-1:0] px_i,
  input  logic signed [POS_W-1:0] py_i,
  input  logic signed [POS_W-1:0] pz_i,
  output logic signed [POS_W-1:0] px_o,
  output logic signed [POS_W-1:0] py_o,
  output logic signed [POS_W-1:0] pz_o
);

  localparam int unsigned P1_W = POS_W + QUAT_W;
  localparam int unsigned S1_W = P1_W + 2;
  localparam int unsigned U_W  = S1_W - QUAT_FRAC_BITS;
  localparam int unsigned P2_W = QUAT_W + U_W;
  localparam int unsigned S2_W = P2_W + 2;
  localparam int unsigned A_W  = S2_W + 1;

  logic signed [QUAT_W-1:0] qx, qy, qz, qw;
  logic signed [POS_W-1:0]  tx, ty, tz;

  assign qx = cfg_i.qx;
  assign qy = cfg_i.qy;
  assign qz = cfg_i.qz;
  assign qw = cfg_i.qw;
  assign tx = cfg_i.tx;
  assign ty = cfg_i.ty;
  assign tz = cfg_i.tz;

  function automatic logic [POS_W-1:0] sat_pos(input logic signed [A_W-1:0] v);
    logic in_range;
    in_range = (&v[A_W-1:POS_W-1]) || !(|v[A_W-1:POS_W-1]);
    if (in_range) begin
      sat_pos = v[POS_W-1:0];
    end else begin
      sat_pos = v[A_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end
  endfunction

  // Stage 1: products of (p,0)*conj(q). The conjugate signs are folded into
  // the sums of stage 2. Rows are u.x, u.y, u.z, u.w.
  logic signed [P1_W-1:0] m1_q [4][3];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      m1_q[0][0] <= px_i * qw;
      m1_q[0][1] <= py_i * qz;
      m1_q[0][2] <= pz_i * qy;
      m1_q[1][0] <= px_i * qz;
      m1_q[1][1] <= py_i * qw;
      m1_q[1][2] <= pz_i * qx;
      m1_q[2][0] <= px_i * qy;
      m1_q[2][1] <= py_i * qx;
      m1_q[2][2] <= pz_i * qw;
      m1_q[3][0] <= px_i * qx;
      m1_q[3][1] <= py_i * qy;
      m1_q[3][2] <= pz_i * qz;
    end
  end

  // Stage 2: sum and arithmetic shift, giving the intermediate quaternion u.
  logic signed [S1_W-1:0] s1 [4];
  logic signed [U_W-1:0]  u_d [4];
  logic signed [U_W-1:0]  u_q [4];

  always_comb begin
    s1[0] = S1_W'(m1_q[0][0]) - S1_W'(m1_q[0][1]) + S1_W'(m1_q[0][2]);
    s1[1] = S1_W'(m1_q[1][0]) + S1_W'(m1_q[1][1]) - S1_W'(m1_q[1][2]);
    s1[2] = S1_W'(m1_q[2][1]) + S1_W'(m1_q[2][2]) - S1_W'(m1_q[2][0]);
    s1[3] = S1_W'(m1_q[3][0]) + S1_W'(m1_q[3][1]) + S1_W'(m1_q[3][2]);
    for (int i = 0; i < 4; i++) begin
      u_d[i] = U_W'(s1[i] >>> QUAT_FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      u_q <= u_d;
    end
  end

  // Stage 3: products of q*u. The scalar part of the result is not needed.
  logic signed [P2_W-1:0] m2_q [3][4];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      m2_q[0][0] <= qw * u_q[0];
      m2_q[0][1] <= qx * u_q[3];
      m2_q[0][2] <= qy * u_q[2];
      m2_q[0][3] <= qz * u_q[1];
      m2_q[1][0] <= qw * u_q[1];
      m2_q[1][1] <= qx * u_q[2];
      m2_q[1][2] <= qy * u_q[3];
      m2_q[1][3] <= qz * u_q[0];
      m2_q[2][0] <= qw * u_q[2];
      m2_q[2][1] <= qx * u_q[1];
      m2_q[2][2] <= qy * u_q[0];
      m2_q[2][3] <= qz * u_q[3];
    end
  end

  // Stage 4: sum and shift, giving the rotated position.
  logic signed [S2_W-1:0] s2 [3];
  logic signed [S2_W-1:0] r_d [3];
  logic signed [S2_W-1:0] r_q [3];

  always_comb begin
    s2[0] = S2_W'(m2_q[0][0]) + S2_W'(m2_q[0][1]) + S2_W'(m2_q[0][2])
          - S2_W'(m2_q[0][3]);
    s2[1] = S2_W'(m2_q[1][0]) - S2_W'(m2_q[1][1]) + S2_W'(m2_q[1][2])
          + S2_W'(m2_q[1][3]);
    s2[2] = S2_W'(m2_q[2][0]) + S2_W'(m2_q[2][1]) - S2_W'(m2_q[2][2])
          + S2_W'(m2_q[2][3]);
    for (int i = 0; i < 3; i++) begin
      r_d[i] = s2[i] >>> QUAT_FRAC_BITS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      r_q <= r_d;
    end
  end

  // Stage 5: add the frame translation and clamp to the position range.
  logic signed [A_W-1:0]   a [3];
  logic signed [POS_W-1:0] p_q [3];

  always_comb begin
    a[0] = A_W'(r_q[0]) + A_W'(tx);
    a[1] = A_W'(r_q[1]) + A_W'(ty);
    a[2] = A_W'(r_q[2]) + A_W'(tz);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < 3; i++) begin
        p_q[i] <= sat_pos(a[i]);
      end
    end
  end

  assign px_o = p_q[0];
  assign py_o = p_q[1];
  assign pz_o = p_q[2];

endmodule
`default_nettype wire

[rtl/se3pc_quat_path.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// se3pc_quat_path: rotation composition pipeline
// Hamilton product q*r in two stages, then a delay line that keeps the
// result aligned with the position path.
// ----------------------------------------------------------------------------
module se3pc_quat_path
  import se3pc_pkg::*;
#(
  parameter int unsigned QUAT_FRAC_BITS = 14
) (
  input  logic                     clk_i,
  input  logic                     adv_i,
  input  frame_cfg_t               cfg_i,
  input  logic signed [QUAT_W-1:0] rx_i,
  input  logic signed [QUAT_W-1:0] ry_i,
  input  logic signed [QUAT_W-1:0] rz_i,
  input  logic signed [QUAT_W-1:0] rw_i,
  output logic signed [QUAT_W-1:0] rx_o,
  output logic signed [QUAT_W-1:0] ry_o,
  output logic signed [QUAT_W-1:0] rz_o,
  output logic signed [QUAT_W-1:0] rw_o
);

  localparam int unsigned M_W   = 2 * QUAT_W;
  localparam int unsigned S_W   = M_W + 2;
  localparam int unsigned DLY_N = NUM_STAGES - 1;

  logic signed [QUAT_W-1:0] qx, qy, qz, qw;

  assign qx = cfg_i.qx;
  assign qy = cfg_i.qy;
  assign qz = cfg_i.qz;
  assign qw = cfg_i.qw;

  function automatic logic [QUAT_W-1:0] sat_quat(input logic signed [S_W-1:0] v);
    logic in_range;
    in_range = (&v[S_W-1:QUAT_W-1]) || !(|v[S_W-1:QUAT_W-1]);
    if (in_range) begin
      sat_quat = v[QUAT_W-1:0];
    end else begin
      sat_quat = v[S_W-1] ? {1'b1, {(QUAT_W-1){1'b0}}} : {1'b0, {(QUAT_W-1){1'b1}}};
    end
  endfunction

  // Stage 1: the sixteen component products. Rows are x, y, z, w.
  logic signed [M_W-1:0] m_q [4][4];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      m_q[0][0] <= qw * rx_i;
      m_q[0][1] <= qx * rw_i;
      m_q[0][2] <= qy * rz_i;
      m_q[0][3] <= qz * ry_i;
      m_q[1][0] <= qw * ry_i;
      m_q[1][1] <= qx * rz_i;
      m_q[1][2] <= qy * rw_i;
      m_q[1][3] <= qz * rx_i;
      m_q[2][0] <= qw * rz_i;
      m_q[2][1] <= qx * ry_i;
      m_q[2][2] <= qy * rx_i;
      m_q[2][3] <= qz * rw_i;
      m_q[3][0] <= qw * rw_i;
      m_q[3][1] <= qx * rx_i;
      m_q[3][2] <= qy * ry_i;
      m_q[3][3] <= qz * rz_i;
    end
  end

  // Stage 2: signed sums, arithmetic shift and saturation.
  logic signed [S_W-1:0] s [4];

  always_comb begin
    s[0] = S_W'(m_q[0][0]) + S_W'(m_q[0][1]) + S_W'(m_q[0][2]) - S_W'(m_q[0][3]);
    s[1] = S_W'(m_q[1][0]) - S_W'(m_q[1][1]) + S_W'(m_q[1][2]) + S_W'(m_q[1][3]);
    s[2] = S_W'(m_q[2][0]) + S_W'(m_q[2][1]) - S_W'(m_q[2][2]) + S_W'(m_q[2][3]);
    s[3] = S_W'(m_q[3][0]) - S_W'(m_q[3][1]) - S_W'(m_q[3][2]) - S_W'(m_q[3][3]);
  end

  // Delay line entry 0 is the stage 2 register, the last entry feeds the ports.
  logic signed [QUAT_W-1:0] dly_q [DLY_N][4];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int c = 0; c < 4; c++) begin
        dly_q[0][c] <= sat_quat(s[c] >>> QUAT_FRAC_BITS);
      end
      for (int k = 1; k < DLY_N; k++) begin
        dly_q[k] <= dly_q[k-1];
      end
    end
  end

  assign rx_o = dly_q[DLY_N-1][0];
  assign ry_o = dly_q[DLY_N-1][1];
  assign rz_o = dly_q[DLY_N-1][2];
  assign rw_o = dly_q[DLY_N-1][3];

endmodule
`default_nettype wire

[rtl/se3_pose_compose_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// se3_pose_compose_top: fixed rigid transform applied to a pose stream
// Rotates each incoming position by the frame quaternion, adds the frame
// translation and composes the incoming rotation with the frame rotation.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake               Payload
//   -------  ---------  ----------------------  -----------------------------
//   in       sink       in_valid_i / in_stall_o  in_p{x,y,z}_i, in_r{x,y,z,w}_i
//   out      source     out_valid_o / out_stall_i out_p{x,y,z}_o, out_r{x,y,z,w}_o
//   cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One pose transaction is accepted in every cycle in which in_stall_o is low. Each
// result passes through the stages of the position path, which sets the depth and
// has two multiplier stages in series, each followed by a summing stage,
// and a final translation and saturation stage.
// Reset clears the stage valid bits and loads the identity frame.
// A stall on a valid output freezes every stage at once and is returned on
// in_stall_o in the same cycle, so no transaction is lost or repeated.
//
module se3_pose_compose_top
  import se3pc_pkg::*;
#(
  parameter int unsigned QUAT_FRAC_BITS = 14
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,

  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,

  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [POS_W-1:0]  in_px_i,
  input  logic signed [POS_W-1:0]  in_py_i,
  input  logic signed [POS_W-1:0]  in_pz_i,
  input  logic signed [QUAT_W-1:0] in_rx_i,
  input  logic signed [QUAT_W-1:0] in_ry_i,
  input  logic signed [QUAT_W-1:0] in_rz_i,
  input  logic signed [QUAT_W-1:0] in_rw_i,

  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [POS_W-1:0]  out_px_o,
  output logic signed [POS_W-1:0]  out_py_o,
  output logic signed [POS_W-1:0]  out_pz_o,
  output logic signed [QUAT_W-1:0] out_rx_o,
  output logic signed [QUAT_W-1:0] out_ry_o,
  output logic signed [QUAT_W-1:0] out_rz_o,
  output logic signed [QUAT_W-1:0] out_rw_o
);

  frame_cfg_t frame_cfg;

  // The pipeline moves whenever the output register is empty or is being
  // taken. Bubbles travel with their valid bit cleared.
  logic                  adv;
  logic [NUM_STAGES-1:0] valid_q, valid_d;

  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  always_comb begin
    valid_d = valid_q;
    if (adv) begin
      valid_d = {valid_q[NUM_STAGES-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign out_valid_o = valid_q[NUM_STAGES-1];

  se3pc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (frame_cfg)
  );

  se3pc_pos_path #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_pos_path (
    .clk_i (clk_i),
    .adv_i (adv),
    .cfg_i (frame_cfg),
    .px_i  (in_px_i),
    .py_i  (in_py_i),
    .pz_i  (in_pz_i),
    .px_o  (out_px_o),
    .py_o  (out_py_o),
    .pz_o  (out_pz_o)
  );

  se3pc_quat_path #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_quat_path (
    .clk_i (clk_i),
    .adv_i (adv),
    .cfg_i (frame_cfg),
    .rx_i  (in_rx_i),
    .ry_i  (in_ry_i),
    .rz_i  (in_rz_i),
    .rw_i  (in_rw_i),
    .rx_o  (out_rx_o),
    .ry_o  (out_ry_o),
    .rz_o  (out_rz_o),
    .rw_o  (out_rw_o)
  );

  // An accepted transaction reaches the output when the output does not stall on its way.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i
      ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted transaction did not reach the output in time");

  // While the output is held, no stage valid bit may move.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(valid_q))
    else $error("pipeline moved while the output was stalled");

  // Without a stall the output valid follows the previous stage.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |=> (out_valid_o == $past(valid_q[NUM_STAGES-2])))
    else $error("output valid does not follow the last stage");

endmodule
`default_nettype wire
